// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the prescaled timer/counter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, disabled while arst_n is low.
`define PTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication on clk, disabled while arst_n is low.
`define PTC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ptc_pkg.sv =====
// Package for the prescaled 8/16-bit timer/counter: codes, field types and structs.
// No dependencies; imported by every module of the block.
package ptc_pkg;

	// Operation code of one input transaction
	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_WR_LOW  = 2'd1,
		FUNC_WR_HIGH = 2'd2,
		FUNC_CLR_OVF = 2'd3
	} func_t;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMER_ENABLE     = 3'd0,
		REG_EIGHT_BIT_MODE   = 3'd1,
		REG_EXTERNAL_CLOCK   = 3'd2,
		REG_FALLING_EDGE     = 3'd3,
		REG_PRESCALER_BYPASS = 3'd4,
		REG_PRESCALE_SELECT  = 3'd5
	} cfg_idx_t;

	localparam int PRESCALE_W = 9;
	localparam int SELECT_W   = 3;

	// Configuration as seen by the counting logic
	typedef struct packed {
		logic                timer_enable;
		logic                eight_bit_mode;
		logic                external_clock;
		logic                falling_edge;
		logic                prescaler_bypass;
		logic [SELECT_W-1:0] prescale_select;
	} cfg_t;

	// One input item
	typedef struct packed {
		func_t      func;
		logic [7:0] write_data;
		logic       pin_level;
		logic       low_byte_touched;
	} item_t;

	// One result item
	typedef struct packed {
		logic [7:0] count_low;
		logic [7:0] count_high;
		logic       overflow_flag;
	} result_t;

endpackage

// ===== rtl/ptc_cfg.sv =====
// Configuration register file of the prescaled timer/counter.
// Depends on ptc_pkg.
module ptc_cfg import ptc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{timer_enable: 1'b1, eight_bit_mode: 1'b1, external_clock: 1'b1,
				falling_edge: 1'b1, prescaler_bypass: 1'b1, prescale_select: '1};
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_TIMER_ENABLE:     cfg_q.timer_enable     <= wr_data[0];
				REG_EIGHT_BIT_MODE:   cfg_q.eight_bit_mode   <= wr_data[0];
				REG_EXTERNAL_CLOCK:   cfg_q.external_clock   <= wr_data[0];
				REG_FALLING_EDGE:     cfg_q.falling_edge     <= wr_data[0];
				REG_PRESCALER_BYPASS: cfg_q.prescaler_bypass <= wr_data[0];
				REG_PRESCALE_SELECT:  cfg_q.prescale_select  <= wr_data[SELECT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ptc_core.sv =====
// Timer state and next-state logic: edge detect, prescaler, 8/16-bit count, overflow.
// Depends on ptc_pkg.
module ptc_core import ptc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    fire,
	output result_t result_nxt
);

	logic [PRESCALE_W-1:0] prescale_q, prescale_nxt, prescale_inc, prescale_limit;
	logic                  prev_pin_q, prev_pin_nxt;
	logic [7:0]            low_q, low_nxt;
	logic [7:0]            high_q, high_nxt;
	logic                  ovf_q, ovf_nxt;
	logic                  event_hit, bump;

	// Counting event qualification and prescaler
	always_comb begin
		if (!cfg.external_clock)
			event_hit = 1'b1;
		else if (!cfg.falling_edge)
			event_hit = !prev_pin_q && item.pin_level;
		else
			event_hit = prev_pin_q && !item.pin_level;
		event_hit      = event_hit && cfg.timer_enable;
		prescale_inc   = item.low_byte_touched ? '0 : prescale_q + 1'b1;
		prescale_limit = PRESCALE_W'(2) << cfg.prescale_select;
		bump           = event_hit && (cfg.prescaler_bypass || prescale_inc >= prescale_limit);
	end

	// Next state per function code
	always_comb begin
		prescale_nxt = prescale_q;
		prev_pin_nxt = prev_pin_q;
		low_nxt      = low_q;
		high_nxt     = high_q;
		ovf_nxt      = ovf_q;
		case (item.func)
			FUNC_TICK: begin
				prev_pin_nxt = item.pin_level;
				if (event_hit)
					prescale_nxt = bump ? '0 : prescale_inc;
				if (bump) begin
					low_nxt = low_q + 8'd1;
					if (low_q == 8'hFF) begin
						if (cfg.eight_bit_mode) begin
							ovf_nxt = 1'b1;
						end else begin
							high_nxt = high_q + 8'd1;
							if (high_q == 8'hFF)
								ovf_nxt = 1'b1;
						end
					end
				end
			end
			FUNC_WR_LOW:  low_nxt  = item.write_data;
			FUNC_WR_HIGH: high_nxt = item.write_data;
			FUNC_CLR_OVF: ovf_nxt  = 1'b0;
			default: ;
		endcase
	end

	// State update once per transaction leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			prev_pin_q <= 1'b0;
			low_q      <= '0;
			high_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (fire) begin
			prescale_q <= prescale_nxt;
			prev_pin_q <= prev_pin_nxt;
			low_q      <= low_nxt;
			high_q     <= high_nxt;
			ovf_q      <= ovf_nxt;
		end
	end

	assign result_nxt = '{count_low: low_nxt, count_high: high_nxt, overflow_flag: ovf_nxt};

endmodule

// ===== rtl/prescaled_timer_counter_8_16.sv =====
// Prescaled 8/16-bit timer/counter: one tick or bus access per input transaction, one
// result transaction per input giving the count bytes and the sticky overflow flag.
// An input transaction is registered, then processed in one pass into the result
// register when that register is free or being drained, and out_valid is driven by
// the result register. The block sustains one transaction per cycle; the only limit
// is out_ready, through the input and result registers. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be issued while no
// transaction is in flight.
// Depends on ptc_pkg, ptc_cfg, ptc_core and assert_macros.svh.
`include "assert_macros.svh"

module prescaled_timer_counter_8_16 import ptc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [7:0]            write_data,
	input  logic                  pin_level,
	input  logic                  low_byte_touched,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            count_low,
	output logic [7:0]            count_high,
	output logic                  overflow_flag
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_nxt;
	result_t result_s2;
	logic    valid_s2;
	logic    out_free, fire;

	assign cfg_ready = 1'b1;

	ptc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or being drained
	assign out_free = !valid_s2 || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= '{func: func_t'(func), write_data: write_data,
				pin_level: pin_level, low_byte_touched: low_byte_touched};
	end

	ptc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item_s1),
		.fire       (fire),
		.result_nxt (result_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			result_s2 <= '0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				result_s2 <= result_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign count_low     = result_s2.count_low;
	assign count_high    = result_s2.count_high;
	assign overflow_flag = result_s2.overflow_flag;

	// Checks
	`PTC_ASSERT(a_stall_blocks_input, (valid_s1 && valid_s2 && !out_ready) |-> !in_ready, "input taken while both stages are stalled")
	`PTC_ASSERT_IMPL(a_ovf_from_tick, fire && item_s1.func != FUNC_TICK && item_s1.func != FUNC_CLR_OVF, overflow_flag == $past(overflow_flag) || $past(valid_s2), "overflow flag changed by a count write")
	`PTC_ASSERT_IMPL(a_write_low, fire && item_s1.func == FUNC_WR_LOW, count_low == $past(item_s1.write_data), "low byte write not reflected in result")
	`PTC_ASSERT_IMPL(a_clear_ovf, fire && item_s1.func == FUNC_CLR_OVF, !overflow_flag, "overflow flag not cleared")

endmodule

// ===== dv/prescaled_timer_counter_8_16_tb.sv =====
// Self-checking testbench for prescaled_timer_counter_8_16: a queue-fed driver, a
// stalling receiver and a monitor that checks each result against a timer predictor.
// Depends on ptc_pkg and the prescaled_timer_counter_8_16 RTL.
module prescaled_timer_counter_8_16_tb import ptc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes past the end of the register list, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int HOLD_CYCLES = 200;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            func = FUNC_TICK;
	logic [7:0]            write_data = '0;
	logic                  pin_level = 1'b0;
	logic                  low_byte_touched = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            count_low;
	logic [7:0]            count_high;
	logic                  overflow_flag;

	// Timer predictor: configuration and state, reset values
	cfg_t       timer_cfg = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7};
	logic [8:0] presc_cnt = '0;
	logic       last_pin = 1'b0;
	logic [7:0] cnt_lo = '0;
	logic [7:0] cnt_hi = '0;
	logic       ovf = 1'b0;

	item_t   item_queue[$];
	result_t expected_counts[$];
	int      fail_count = 0;
	int      hold_requests = 0;
	logic    pin_track = 1'b0;

	prescaled_timer_counter_8_16 u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.write_data       (write_data),
		.pin_level        (pin_level),
		.low_byte_touched (low_byte_touched),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.count_low        (count_low),
		.count_high       (count_high),
		.overflow_flag    (overflow_flag)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one transaction to the predicted timer state and return the counts after it
	function automatic result_t advance_timer(item_t it);
		logic    evt;
		result_t res;
		evt = 1'b0;
		case (it.func)
			FUNC_TICK: begin
				if (timer_cfg.timer_enable) begin
					if (!timer_cfg.external_clock)
						evt = 1'b1;
					else if (!timer_cfg.falling_edge)
						evt = !last_pin && it.pin_level;
					else
						evt = last_pin && !it.pin_level;
					if (evt) begin
						presc_cnt = presc_cnt + 9'd1;
						// a low-byte access clears the prescaler, but only on a counting event
						if (it.low_byte_touched)
							presc_cnt = '0;
						// >= so a count past a freshly lowered limit fires at once
						if (timer_cfg.prescaler_bypass ||
								int'(presc_cnt) >= (2 << timer_cfg.prescale_select)) begin
							presc_cnt = '0;
							cnt_lo = cnt_lo + 8'd1;
							if (cnt_lo == 8'd0) begin
								if (timer_cfg.eight_bit_mode) begin
									ovf = 1'b1;
								end else begin
									cnt_hi = cnt_hi + 8'd1;
									if (cnt_hi == 8'd0)
										ovf = 1'b1;
								end
							end
						end
					end
				end
				// pin is sampled even with the timer disabled
				last_pin = it.pin_level;
			end
			FUNC_WR_LOW:  cnt_lo = it.write_data;
			FUNC_WR_HIGH: cnt_hi = it.write_data;
			default:      ovf = 1'b0;
		endcase
		res.count_low = cnt_lo;
		res.count_high = cnt_hi;
		res.overflow_flag = ovf;
		return res;
	endfunction

	// Driver: bursts of transactions from item_queue with random gaps between bursts
	always @(posedge clk) begin : driver
		item_t pending_item;
		int    burst_left;
		int    gap_left;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_counts.push_back(advance_timer(pending_item));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (item_queue.size() != 0) begin
					pending_item = item_queue.pop_front();
					in_valid <= 1'b1;
					func <= pending_item.func;
					write_data <= pending_item.write_data;
					pin_level <= pending_item.pin_level;
					low_byte_touched <= pending_item.low_byte_touched;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern that changes at random intervals, plus requested long holds
	always @(posedge clk) begin : receiver
		int       holds_served;
		int       hold_left;
		int       mode_age;
		int       rx_cycle;
		rx_mode_e stall_mode;
		rx_cycle = rx_cycle + 1;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_age <= 0) begin
				stall_mode = rx_mode_e'($urandom_range(0, 3));
				mode_age = $urandom_range(16, 96);
			end else begin
				mode_age = mode_age - 1;
			end
			case (stall_mode)
				RX_ALWAYS:   out_ready <= 1'b1;
				RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
				RX_MOSTLY:   out_ready <= ($urandom_range(0, 9) != 0);
				RX_PERIODIC: out_ready <= (rx_cycle % 7 < 4);
				default:     out_ready <= 1'b1;
			endcase
		end
	end

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result low %02h high %02h ovf %0b", $time,
					count_low, count_high, overflow_flag);
				fail_count = fail_count + 1;
			end else begin
				want = expected_counts.pop_front();
				if (count_low !== want.count_low) begin
					$display("%0t: count_low expected %02h actual %02h", $time,
						want.count_low, count_low);
					fail_count = fail_count + 1;
				end
				if (count_high !== want.count_high) begin
					$display("%0t: count_high expected %02h actual %02h", $time,
						want.count_high, count_high);
					fail_count = fail_count + 1;
				end
				if (overflow_flag !== want.overflow_flag) begin
					$display("%0t: overflow_flag expected %0b actual %0b", $time,
						want.overflow_flag, overflow_flag);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	// Wait until nothing is queued, offered or outstanding; sampled at the falling edge
	// so the driver and monitor have finished their work for the rising edge
	task automatic settle();
		while (item_queue.size() != 0 || in_valid || expected_counts.size() != 0)
			@(negedge clk);
	endtask

	// One register write transaction; the predictor takes it at acceptance
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIMER_ENABLE:     timer_cfg.timer_enable = val[0];
			REG_EIGHT_BIT_MODE:   timer_cfg.eight_bit_mode = val[0];
			REG_EXTERNAL_CLOCK:   timer_cfg.external_clock = val[0];
			REG_FALLING_EDGE:     timer_cfg.falling_edge = val[0];
			REG_PRESCALER_BYPASS: timer_cfg.prescaler_bypass = val[0];
			REG_PRESCALE_SELECT:  timer_cfg.prescale_select = val[2:0];
			default: ;
		endcase
	endtask

	// Value in bit 0 (keep 1) or in bits 2:0 (otherwise), random junk above it
	function automatic logic [7:0] with_junk(logic [2:0] v, int keep);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		return (keep == 1) ? {junk[7:1], v[0]} : {junk[7:3], v};
	endfunction

	task automatic queue_item(func_t f, logic [7:0] d, logic p, logic t);
		item_t it;
		it.func = f;
		it.write_data = d;
		it.pin_level = p;
		it.low_byte_touched = t;
		item_queue.push_back(it);
	endtask

	// Random transactions, mostly ticks with a pin that toggles often
	task automatic queue_random(int count);
		int         pick;
		func_t      f;
		logic [7:0] d;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				f = FUNC_TICK;
			else if (pick < 80)
				f = FUNC_WR_LOW;
			else if (pick < 90)
				f = FUNC_WR_HIGH;
			else
				f = FUNC_CLR_OVF;
			case ($urandom_range(0, 7))
				0:       d = 8'hFF;
				1:       d = 8'hFE;
				2:       d = 8'h00;
				default: d = 8'($urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 1) == 1)
				pin_track = !pin_track;
			queue_item(f, d, pin_track, ($urandom_range(0, 9) == 0));
		end
	endtask

	initial begin : stimulus
		int         n_sent;
		int         phase;
		logic [7:0] en, eight, ext, fall, byp, sel;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset setting counts falling pin edges, bypassed, 8-bit
		queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b0);
		queue_item(FUNC_TICK, 8'hFF, 1'b0, 1'b0);
		queue_item(FUNC_WR_LOW, 8'hFF, 1'b1, 1'b1);
		queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b1);
		queue_item(FUNC_WR_HIGH, 8'hAB, 1'b0, 1'b0);
		queue_item(FUNC_CLR_OVF, 8'h55, 1'b1, 1'b1);
		queue_item(FUNC_WR_HIGH, 8'h00, 1'b0, 1'b0);
		settle();
		// 16-bit wrap on internal ticks
		write_reg(REG_EXTERNAL_CLOCK, 8'h00);
		write_reg(REG_EIGHT_BIT_MODE, 8'hFE);
		queue_item(FUNC_WR_LOW, 8'hFF, 1'b0, 1'b0);
		queue_item(FUNC_WR_HIGH, 8'hFF, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b1);
		settle();
		// Divide by two; a low-byte access resets the prescaler
		write_reg(REG_PRESCALER_BYPASS, 8'h00);
		write_reg(REG_PRESCALE_SELECT, 8'h00);
		write_reg(REG_SPARE_6, 8'hFF);
		write_reg(REG_SPARE_7, 8'h00);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b1);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		settle();
		// Lowering the select with a count already past the new limit
		write_reg(REG_PRESCALE_SELECT, 8'h07);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		settle();
		write_reg(REG_PRESCALE_SELECT, 8'hF8);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		settle();
		// Disabled timer still samples the pin; then rising edges
		write_reg(REG_TIMER_ENABLE, 8'h00);
		write_reg(REG_EXTERNAL_CLOCK, 8'h01);
		write_reg(REG_FALLING_EDGE, 8'h00);
		queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		settle();
		write_reg(REG_TIMER_ENABLE, 8'h01);
		queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
		queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b0);
		pin_track = 1'b1;

		// Random phases, each under a fresh setting
		n_sent = 0;
		phase = 0;
		while (n_sent < 1750) begin
			int n;
			settle();
			if (phase == 0) begin
				en = 8'hFF; eight = 8'hFF; ext = 8'hFF; fall = 8'hFF; byp = 8'hFF; sel = 8'hFF;
			end else if (phase == 1) begin
				en = 8'h00; eight = 8'h00; ext = 8'h00; fall = 8'h00; byp = 8'h00; sel = 8'h00;
			end else begin
				en = with_junk(3'($urandom_range(0, 6) != 0), 1);
				eight = with_junk(3'($urandom_range(0, 1)), 1);
				ext = with_junk(3'($urandom_range(0, 1)), 1);
				fall = with_junk(3'($urandom_range(0, 1)), 1);
				byp = with_junk(3'($urandom_range(0, 4) < 2), 1);
				case ($urandom_range(0, 9))
					0, 1, 2: sel = with_junk(3'd0, 3);
					3, 4:    sel = with_junk(3'd7, 3);
					default: sel = with_junk(3'($urandom_range(0, 7)), 3);
				endcase
			end
			write_reg(REG_TIMER_ENABLE, en);
			write_reg(REG_EIGHT_BIT_MODE, eight);
			write_reg(REG_EXTERNAL_CLOCK, ext);
			write_reg(REG_FALLING_EDGE, fall);
			write_reg(REG_PRESCALER_BYPASS, byp);
			write_reg(REG_PRESCALE_SELECT, sel);
			if ($urandom_range(0, 4) == 0)
				write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_6 : REG_SPARE_7,
					8'($urandom_range(0, 255)));
			// long receiver hold while the sender keeps offering
			if (phase == 3 || phase == 11)
				hold_requests = hold_requests + 1;
			n = $urandom_range(40, 120);
			queue_random(n);
			n_sent = n_sent + n;
			phase = phase + 1;
		end

		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard limit on run time
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
